// File: src/crsp_pkg.sv
// Shared types, widths and helpers for the camera ray unit.
package crsp_pkg;

    localparam int IN_W       = 18;   // click coordinate, Q1.16
    localparam int DX_W       = 17;   // centered coordinate while on screen
    localparam int SCALE_W    = 32;   // unsigned Q16.16 scale factors
    localparam int PROD_W     = 50;   // scale * centered coordinate
    localparam int OFF_W      = 33;   // camera-space offset, signed Q16.16
    localparam int MAG_W      = 32;   // magnitude of one offset component
    localparam int SQ_W       = 64;   // sum of squares
    localparam int ROOT_W     = 32;   // integer square root
    localparam int NUM_W      = 48;   // divider remainder
    localparam int Q_W        = 15;   // normalized component magnitude
    localparam int COEF_W     = 16;   // quaternion coefficient, Q1.14
    localparam int QUAT_W     = 64;
    localparam int UV_W       = 36;   // first cross product
    localparam int T_W        = 54;   // w*uv + u x uv
    localparam int ROT_W      = 42;   // rotated vector
    localparam int POS_W      = 21;   // camera position component, Q10.10
    localparam int POS_SHIFT  = 6;
    localparam int START_W    = 43;   // position + rotated offset
    localparam int OUT_W      = 32;
    localparam int DIR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int FRAC_SHIFT = 16;
    localparam int COEF_SHIFT = 14;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;

    localparam int ONE_Q16  = 65536;
    localparam int HALF_Q16 = 32768;
    localparam int ONE_Q14  = 16384;
    localparam int HALF_Q14 = 8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_POSITION = 3'd1,
        REG_ROTATION = 3'd2,
        REG_ORTHO    = 3'd3,
        REG_TAN      = 3'd4,
        REG_ASPECT   = 3'd5,
        REG_NEAR     = 3'd6,
        REG_FAR      = 3'd7
    } cfg_reg_t;

    typedef logic signed [OFF_W-1:0] off_t;

    typedef struct packed {
        logic       in_view;
        logic       persp;
        off_t [2:0] off;
    } ray_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } root_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] rem;
        logic [2:0][Q_W-1:0]   quot;
        logic [ROOT_W-1:0]     root;
    } quot_t;

    function automatic logic [MAG_W-1:0] mag_of(input off_t v);
        logic signed [OFF_W-1:0] n;
        n = -v;
        return v[OFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

// File: src/crsp_front.sv
// Front stages: screen test, camera-space offset, squared length.
module crsp_front (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic                                     valid_in,
    input  logic signed [crsp_pkg::IN_W-1:0]         click_x,
    input  logic signed [crsp_pkg::IN_W-1:0]         click_y,
    input  logic                                     persp,
    input  logic [crsp_pkg::SCALE_W-1:0]             scale_x,
    input  logic [crsp_pkg::SCALE_W-1:0]             scale_y,
    input  logic [crsp_pkg::OFF_W-3:0]               near,
    output logic                                     valid_out,
    output crsp_pkg::ray_t                           ray_out,
    output logic [crsp_pkg::SQ_W-1:0]                sum_out
);

    localparam int IN_W   = crsp_pkg::IN_W;
    localparam int DX_W   = crsp_pkg::DX_W;
    localparam int PROD_W = crsp_pkg::PROD_W;
    localparam int OFF_W  = crsp_pkg::OFF_W;
    localparam int SQ_W   = crsp_pkg::SQ_W;
    localparam int MAG_W  = crsp_pkg::MAG_W;
    localparam logic signed [IN_W-1:0] ONE_IN  = IN_W'(crsp_pkg::ONE_Q16);
    localparam logic signed [IN_W-1:0] HALF_IN = IN_W'(crsp_pkg::HALF_Q16);
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(crsp_pkg::HALF_Q16);

    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [IN_W-1:0]   x1_reg, y1_reg;
    logic signed [PROD_W-1:0] px2_reg, py2_reg;
    logic                     view2_reg, persp2_reg;
    crsp_pkg::ray_t           ray3_reg, ray4_reg, ray5_reg;
    logic [SQ_W-1:0]          sq4_reg [3];
    logic [SQ_W-1:0]          sum5_reg;

    logic                     view1;
    logic signed [DX_W-1:0]   dx1, dy1;
    logic signed [PROD_W-1:0] px1, py1;
    crsp_pkg::ray_t           ray3_next;
    logic [MAG_W-1:0]         mag3 [3];
    logic [SQ_W-1:0]          sq3 [3];

    // stage 1: on-screen test and centering
    assign view1 = !x1_reg[IN_W-1] && !y1_reg[IN_W-1] && (x1_reg <= ONE_IN) && (y1_reg <= ONE_IN);
    assign dx1   = DX_W'(x1_reg - HALF_IN);
    assign dy1   = DX_W'(HALF_IN - y1_reg);
    assign px1   = PROD_W'($signed({1'b0, scale_x})) * PROD_W'(dx1);
    assign py1   = PROD_W'($signed({1'b0, scale_y})) * PROD_W'(dy1);

    // stage 2: round products back to Q16.16
    always_comb
    begin
        ray3_next.in_view = view2_reg;
        ray3_next.persp   = persp2_reg;
        ray3_next.off[0]  = OFF_W'((px2_reg + HALF_P) >>> crsp_pkg::FRAC_SHIFT);
        ray3_next.off[1]  = OFF_W'((py2_reg + HALF_P) >>> crsp_pkg::FRAC_SHIFT);
        ray3_next.off[2]  = -$signed(OFF_W'(near));
    end

    // stage 3: squares of the magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag3[i] = crsp_pkg::mag_of(ray3_reg.off[i]);
            sq3[i]  = SQ_W'(mag3[i]) * SQ_W'(mag3[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg     <= click_x;
            y1_reg     <= click_y;
            px2_reg    <= px1;
            py2_reg    <= py1;
            view2_reg  <= view1;
            persp2_reg <= persp;
            ray3_reg   <= ray3_next;
            ray4_reg   <= ray3_reg;
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= sq3[i];
            ray5_reg   <= ray4_reg;
            sum5_reg   <= sq4_reg[0] + sq4_reg[1] + sq4_reg[2];
        end
    end

    assign valid_out = v5_reg;
    assign ray_out   = ray5_reg;
    assign sum_out   = sum5_reg;

endmodule

// File: src/crsp_sqrt_step.sv
// One digit step of the pipelined integer square root.
module crsp_sqrt_step #(
    parameter int BIT_POS = crsp_pkg::SQ_W - 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  crsp_pkg::ray_t  ray_in,
    input  crsp_pkg::root_t acc_in,
    output logic            valid_out,
    output crsp_pkg::ray_t  ray_out,
    output crsp_pkg::root_t acc_out
);

    localparam int W = crsp_pkg::SQ_W;
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << BIT_POS;

    logic            valid_reg;
    crsp_pkg::ray_t  ray_reg;
    crsp_pkg::root_t acc_reg, acc_next;
    logic [W-1:0]    trial;

    always_comb
    begin
        trial = acc_in.res + BIT;
        if (acc_in.rem >= trial)
        begin
            acc_next.rem = acc_in.rem - trial;
            acc_next.res = (acc_in.res >> 1) + BIT;
        end
        else
        begin
            acc_next.rem = acc_in.rem;
            acc_next.res = acc_in.res >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg <= ray_in;
            acc_reg <= acc_next;
        end
    end

    assign valid_out = valid_reg;
    assign ray_out   = ray_reg;
    assign acc_out   = acc_reg;

endmodule

// File: src/crsp_div_step.sv
// One restoring-division step for the three normalization lanes.
module crsp_div_step #(
    parameter int SHIFT = crsp_pkg::Q_W - 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            valid_in,
    input  crsp_pkg::ray_t  ray_in,
    input  crsp_pkg::quot_t acc_in,
    output logic            valid_out,
    output crsp_pkg::ray_t  ray_out,
    output crsp_pkg::quot_t acc_out
);

    localparam int NUM_W = crsp_pkg::NUM_W;

    logic            valid_reg;
    crsp_pkg::ray_t  ray_reg;
    crsp_pkg::quot_t acc_reg, acc_next;
    logic [NUM_W-1:0] den;

    // divisor is 2*root
    assign den = NUM_W'({acc_in.root, 1'b0}) << SHIFT;

    always_comb
    begin
        acc_next = acc_in;
        for (int i = 0; i < 3; i++)
        begin
            if (acc_in.rem[i] >= den)
            begin
                acc_next.rem[i]        = acc_in.rem[i] - den;
                acc_next.quot[i][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ray_reg <= ray_in;
            acc_reg <= acc_next;
        end
    end

    assign valid_out = valid_reg;
    assign ray_out   = ray_reg;
    assign acc_out   = acc_reg;

endmodule

// File: src/crsp_rotate.sv
// Three-stage quaternion rotation of the offset and direction vectors.
module crsp_rotate (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        valid_in,
    input  logic                                        view_in,
    input  logic [crsp_pkg::QUAT_W-1:0]                 quat,
    input  crsp_pkg::off_t [1:0][2:0]                   vec,
    output logic                                        valid_out,
    output logic                                        view_out,
    output logic [1:0][2:0][crsp_pkg::ROT_W-1:0]        rot
);

    localparam int COEF_W = crsp_pkg::COEF_W;
    localparam int UV_W   = crsp_pkg::UV_W;
    localparam int T_W    = crsp_pkg::T_W;
    localparam int T2_W   = T_W + 1;
    localparam int ROT_W  = crsp_pkg::ROT_W;
    localparam int OFF_W  = crsp_pkg::OFF_W;
    localparam int SH     = crsp_pkg::COEF_SHIFT;
    localparam logic signed [T_W-1:0]  HALF_T  = T_W'(crsp_pkg::HALF_Q14);
    localparam logic signed [T2_W-1:0] HALF_T2 = T2_W'(crsp_pkg::HALF_Q14);

    logic signed [COEF_W-1:0] qw, qx, qy, qz;
    logic [2:0] valid_reg, view_reg;

    assign qw = $signed(quat[0*COEF_W +: COEF_W]);
    assign qx = $signed(quat[1*COEF_W +: COEF_W]);
    assign qy = $signed(quat[2*COEF_W +: COEF_W]);
    assign qz = $signed(quat[3*COEF_W +: COEF_W]);

    // a*b - c*d
    function automatic logic signed [T_W-1:0] xterm(
        input logic signed [COEF_W-1:0] a,
        input logic signed [UV_W-1:0]   b,
        input logic signed [COEF_W-1:0] c,
        input logic signed [UV_W-1:0]   d
    );
        return T_W'(a) * T_W'(b) - T_W'(c) * T_W'(d);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            view_reg  <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], valid_in};
            view_reg  <= {view_reg[1:0], view_in};
        end
    end

    assign valid_out = valid_reg[2];
    assign view_out  = view_reg[2];

    for (genvar g = 0; g < 2; g++)
    begin : g_vec
        logic signed [UV_W-1:0]  v0, v1, v2;
        logic signed [UV_W-1:0]  uv_next [3];
        logic signed [UV_W-1:0]  uv_reg [3];
        logic signed [T_W-1:0]   t_next [3];
        logic signed [T_W-1:0]   t_reg [3];
        logic signed [OFF_W-1:0] va_reg [3];
        logic signed [OFF_W-1:0] vb_reg [3];
        logic signed [ROT_W-1:0] r_next [3];
        logic signed [ROT_W-1:0] r_reg [3];

        assign v0 = UV_W'($signed(vec[g][0]));
        assign v1 = UV_W'($signed(vec[g][1]));
        assign v2 = UV_W'($signed(vec[g][2]));

        // u x v, rounded back to the units of v
        assign uv_next[0] = UV_W'((xterm(qy, v2, qz, v1) + HALF_T) >>> SH);
        assign uv_next[1] = UV_W'((xterm(qz, v0, qx, v2) + HALF_T) >>> SH);
        assign uv_next[2] = UV_W'((xterm(qx, v1, qy, v0) + HALF_T) >>> SH);

        // w*uv + u x uv
        assign t_next[0] = T_W'(qw) * T_W'(uv_reg[0]) + xterm(qy, uv_reg[2], qz, uv_reg[1]);
        assign t_next[1] = T_W'(qw) * T_W'(uv_reg[1]) + xterm(qz, uv_reg[0], qx, uv_reg[2]);
        assign t_next[2] = T_W'(qw) * T_W'(uv_reg[2]) + xterm(qx, uv_reg[1], qy, uv_reg[0]);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
                r_next[i] = ROT_W'(((T2_W'(t_reg[i]) <<< 1) + HALF_T2) >>> SH)
                          + ROT_W'(vb_reg[i]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    uv_reg[i] <= uv_next[i];
                    va_reg[i] <= $signed(vec[g][i]);
                    t_reg[i]  <= t_next[i];
                    vb_reg[i] <= va_reg[i];
                    r_reg[i]  <= r_next[i];
                end
            end
        end

        for (genvar k = 0; k < 3; k++)
        begin : g_out
            assign rot[g][k] = r_reg[k];
        end
    end

endmodule

// File: src/camera_ray_from_screen_point_unit.sv
// Top level of the camera ray unit: config registers, pipeline and output register.
//
// Turns a normalized screen point (click_x, click_y, Q1.16, y down) into a
// world-space ray: start point (Q16.16), unit direction (Q1.14) and length.
// Input channel: in_valid / in_stall; a transfer happens on a rising edge with
// in_valid high and in_stall low. Output channel: out_valid / out_stall, same
// rule, one result per input, in order.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write config only while the pipeline is empty.
// Throughput: one point per clock while the output is not stalled. Latency: 56
// register stages between an input transfer and its result on out_valid.
// The depth comes from the 32-step square root and the 15-step divider that
// normalize the perspective direction.
// Stall: the whole pipeline advances only when the output register is empty or
// being taken; while out_stall holds a full output register, in_stall is high
// and every stage holds its contents.
// Reset (rst_n, async, active low) empties the pipeline and loads the default
// camera: perspective, at origin, identity rotation.
module camera_ray_from_screen_point_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [crsp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [crsp_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [crsp_pkg::IN_W-1:0]       click_x,
    input  logic signed [crsp_pkg::IN_W-1:0]       click_y,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   in_view,
    output logic signed [crsp_pkg::OUT_W-1:0]      start_x,
    output logic signed [crsp_pkg::OUT_W-1:0]      start_y,
    output logic signed [crsp_pkg::OUT_W-1:0]      start_z,
    output logic signed [crsp_pkg::DIR_W-1:0]      dir_x,
    output logic signed [crsp_pkg::DIR_W-1:0]      dir_y,
    output logic signed [crsp_pkg::DIR_W-1:0]      dir_z,
    output logic signed [crsp_pkg::OUT_W-1:0]      ray_length
);

    localparam int SQRT_STEPS = crsp_pkg::SQRT_STEPS;
    localparam int DIV_STEPS  = crsp_pkg::DIV_STEPS;
    localparam int SQ_W       = crsp_pkg::SQ_W;
    localparam int ROOT_W     = crsp_pkg::ROOT_W;
    localparam int NUM_W      = crsp_pkg::NUM_W;
    localparam int Q_W        = crsp_pkg::Q_W;
    localparam int OFF_W      = crsp_pkg::OFF_W;
    localparam int ROT_W      = crsp_pkg::ROT_W;
    localparam int START_W    = crsp_pkg::START_W;
    localparam int OUT_W      = crsp_pkg::OUT_W;
    localparam int DIR_W      = crsp_pkg::DIR_W;
    localparam int POS_W      = crsp_pkg::POS_W;
    localparam int SCALE_W    = crsp_pkg::SCALE_W;
    localparam int AT_W       = 2 * SCALE_W;
    localparam int DIST_W     = OFF_W - 2;
    localparam logic signed [ROT_W-1:0] DIR_HI = ROT_W'(crsp_pkg::ONE_Q14);
    localparam logic signed [ROT_W-1:0] DIR_LO = -DIR_HI;
    localparam logic signed [OFF_W-1:0] MINUS_ONE_Q14 = -OFF_W'(crsp_pkg::ONE_Q14);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic                          persp_reg;
    logic [3*POS_W-1:0]            position_reg;
    logic [crsp_pkg::QUAT_W-1:0]   rotation_reg;
    logic [2*SCALE_W-1:0]          ortho_reg;
    logic [SCALE_W-1:0]            tan_reg;
    logic [SCALE_W-1:0]            aspect_reg;
    logic [DIST_W-1:0]             near_reg;
    logic [DIST_W-1:0]             far_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            persp_reg    <= 1'b1;
            position_reg <= '0;
            rotation_reg <= crsp_pkg::QUAT_W'(crsp_pkg::ONE_Q14);
            ortho_reg    <= '0;
            tan_reg      <= SCALE_W'(crsp_pkg::ONE_Q16);
            aspect_reg   <= SCALE_W'(crsp_pkg::ONE_Q16);
            near_reg     <= DIST_W'(6554);
            far_reg      <= DIST_W'(6553600);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (crsp_pkg::cfg_reg_t'(cfg_index))
                crsp_pkg::REG_MODE:     persp_reg    <= cfg_data[0];
                crsp_pkg::REG_POSITION: position_reg <= cfg_data[3*POS_W-1:0];
                crsp_pkg::REG_ROTATION: rotation_reg <= cfg_data;
                crsp_pkg::REG_ORTHO:    ortho_reg    <= cfg_data;
                crsp_pkg::REG_TAN:      tan_reg      <= cfg_data[SCALE_W-1:0];
                crsp_pkg::REG_ASPECT:   aspect_reg   <= cfg_data[SCALE_W-1:0];
                crsp_pkg::REG_NEAR:     near_reg     <= cfg_data[DIST_W-1:0];
                crsp_pkg::REG_FAR:      far_reg      <= cfg_data[DIST_W-1:0];
                default:                persp_reg    <= persp_reg;
            endcase
        end
    end

    // aspect*tan, rounded and saturated; refreshed every cycle from config
    logic [AT_W-1:0]    at_prod, at_round;
    logic [SCALE_W-1:0] at_reg;

    assign at_prod  = AT_W'(aspect_reg) * AT_W'(tan_reg);
    assign at_round = (at_prod + AT_W'(crsp_pkg::HALF_Q16)) >> crsp_pkg::FRAC_SHIFT;

    always_ff @(posedge clk)
    begin
        at_reg <= (|at_round[AT_W-1:SCALE_W]) ? '1 : at_round[SCALE_W-1:0];
    end

    // ---------------------------------------------------------------
    // flow control: every stage moves together
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic adv;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    // ---------------------------------------------------------------
    // front: screen test, offset, sum of squares
    // ---------------------------------------------------------------
    logic            sq_valid [SQRT_STEPS+1];
    crsp_pkg::ray_t  sq_ray   [SQRT_STEPS+1];
    crsp_pkg::root_t sq_acc   [SQRT_STEPS+1];
    logic [SQ_W-1:0] front_sum;

    crsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (in_valid),
        .click_x   (click_x),
        .click_y   (click_y),
        .persp     (persp_reg),
        .scale_x   (persp_reg ? at_reg : ortho_reg[SCALE_W-1:0]),
        .scale_y   (persp_reg ? tan_reg : ortho_reg[2*SCALE_W-1:SCALE_W]),
        .near      (near_reg),
        .valid_out (sq_valid[0]),
        .ray_out   (sq_ray[0]),
        .sum_out   (front_sum)
    );

    assign sq_acc[0].rem = front_sum;
    assign sq_acc[0].res = '0;

    // ---------------------------------------------------------------
    // square root, one result bit per stage
    // ---------------------------------------------------------------
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        crsp_sqrt_step #(
            .BIT_POS (SQ_W - 2 - 2 * k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (sq_valid[k]),
            .ray_in    (sq_ray[k]),
            .acc_in    (sq_acc[k]),
            .valid_out (sq_valid[k+1]),
            .ray_out   (sq_ray[k+1]),
            .acc_out   (sq_acc[k+1])
        );
    end

    // ---------------------------------------------------------------
    // normalization: c = (|off|*2^15 + n) / (2n), one quotient bit per stage
    // ---------------------------------------------------------------
    logic            dv_valid [DIV_STEPS+1];
    crsp_pkg::ray_t  dv_ray   [DIV_STEPS+1];
    crsp_pkg::quot_t dv_acc   [DIV_STEPS+1];
    logic [ROOT_W-1:0] root;

    assign root        = sq_acc[SQRT_STEPS].res[ROOT_W-1:0];
    assign dv_valid[0] = sq_valid[SQRT_STEPS];
    assign dv_ray[0]   = sq_ray[SQRT_STEPS];

    always_comb
    begin
        dv_acc[0].root = root;
        for (int i = 0; i < 3; i++)
        begin
            dv_acc[0].quot[i] = '0;
            dv_acc[0].rem[i]  = NUM_W'({crsp_pkg::mag_of(sq_ray[SQRT_STEPS].off[i]),
                                        {(Q_W){1'b0}}}) + NUM_W'(root);
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        crsp_div_step #(
            .SHIFT (Q_W - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (dv_valid[k]),
            .ray_in    (dv_ray[k]),
            .acc_in    (dv_acc[k]),
            .valid_out (dv_valid[k+1]),
            .ray_out   (dv_ray[k+1]),
            .acc_out   (dv_acc[k+1])
        );
    end

    // direction before rotation: -Z in ortho mode or for a zero-length offset
    crsp_pkg::ray_t                  dv_last;
    crsp_pkg::off_t [1:0][2:0]       rot_vec;
    logic                            use_base;

    assign dv_last  = dv_ray[DIV_STEPS];
    assign use_base = !dv_last.persp || (dv_acc[DIV_STEPS].root == '0);

    always_comb
    begin
        rot_vec[0] = dv_last.off;
        for (int i = 0; i < 3; i++)
        begin
            if (use_base)
                rot_vec[1][i] = (i == 2) ? MINUS_ONE_Q14 : '0;
            else if (dv_last.off[i][OFF_W-1])
                rot_vec[1][i] = -$signed(OFF_W'(dv_acc[DIV_STEPS].quot[i]));
            else
                rot_vec[1][i] = OFF_W'(dv_acc[DIV_STEPS].quot[i]);
        end
    end

    // ---------------------------------------------------------------
    // rotation of offset and direction
    // ---------------------------------------------------------------
    logic                            rot_valid, rot_view;
    logic [1:0][2:0][ROT_W-1:0]      rot;

    crsp_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .valid_in  (dv_valid[DIV_STEPS]),
        .view_in   (dv_last.in_view),
        .quat      (rotation_reg),
        .vec       (rot_vec),
        .valid_out (rot_valid),
        .view_out  (rot_view),
        .rot       (rot)
    );

    // ---------------------------------------------------------------
    // final: add camera position, saturate, output register
    // ---------------------------------------------------------------
    logic signed [START_W-1:0] pos_ext [3];
    logic signed [START_W-1:0] start_sum [3];
    logic signed [OUT_W-1:0]   start_next [3];
    logic signed [DIR_W-1:0]   dir_next [3];
    logic signed [ROT_W-1:0]   dir_raw [3];
    logic signed [OUT_W-1:0]   length_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_ext[i]   = START_W'($signed(position_reg[POS_W*i +: POS_W]))
                           <<< crsp_pkg::POS_SHIFT;
            start_sum[i] = pos_ext[i] + START_W'($signed(rot[0][i]));
            if (!start_sum[i][START_W-1] && (|start_sum[i][START_W-2:OUT_W-1]))
                start_next[i] = {1'b0, {(OUT_W-1){1'b1}}};
            else if (start_sum[i][START_W-1] && !(&start_sum[i][START_W-2:OUT_W-1]))
                start_next[i] = {1'b1, {(OUT_W-1){1'b0}}};
            else
                start_next[i] = start_sum[i][OUT_W-1:0];

            dir_raw[i] = $signed(rot[1][i]);
            if (dir_raw[i] > DIR_HI)
                dir_next[i] = DIR_W'(DIR_HI);
            else if (dir_raw[i] < DIR_LO)
                dir_next[i] = DIR_W'(DIR_LO);
            else
                dir_next[i] = DIR_W'(dir_raw[i]);
        end
        length_next = $signed(OUT_W'(far_reg)) - $signed(OUT_W'(near_reg));
    end

    logic                    view_reg;
    logic signed [OUT_W-1:0] start_reg [3];
    logic signed [DIR_W-1:0] dir_reg [3];
    logic signed [OUT_W-1:0] length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= rot_valid;
    end

    // off-screen points deliver all-zero fields
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            view_reg   <= rot_view;
            length_reg <= rot_view ? length_next : '0;
            for (int i = 0; i < 3; i++)
            begin
                start_reg[i] <= rot_view ? start_next[i] : '0;
                dir_reg[i]   <= rot_view ? dir_next[i] : '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign in_view    = view_reg;
    assign start_x    = start_reg[0];
    assign start_y    = start_reg[1];
    assign start_z    = start_reg[2];
    assign dir_x      = dir_reg[0];
    assign dir_y      = dir_reg[1];
    assign dir_z      = dir_reg[2];
    assign ray_length = length_reg;

`ifndef ASSERT_OFF
    a_off_screen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_view) |-> (start_x == 0 && start_y == 0 && start_z == 0 &&
                                     dir_x == 0 && dir_y == 0 && dir_z == 0 &&
                                     ray_length == 0))
        else $error("off-screen result carries nonzero fields");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dir_x >= -16384 && dir_x <= 16384 && dir_y >= -16384 &&
                       dir_y <= 16384 && dir_z >= -16384 && dir_z <= 16384))
        else $error("direction component outside unit range");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(rot_valid) && $stable(sq_valid[SQRT_STEPS])
                                      && $stable(dv_valid[DIV_STEPS])))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the camera ray unit: directed table, then random points.
`timescale 1ns / 1ps

// Checks every ray in order against an expected ray. Each configuration phase
// loads the camera registers, then streams points with random idle cycles on
// the input and output sides. A table of directed points comes first; eight
// rows carry a typed-in expected ray, the rest are checked by a behavioral predictor.
module testbench;

    localparam int LATENCY = 56;

    typedef struct {
        logic                in_view;
        logic signed [31:0]  start_x, start_y, start_z;
        logic signed [15:0]  dir_x, dir_y, dir_z;
        logic signed [31:0]  ray_length;
    } ray_result_t;

    typedef struct {
        logic signed [17:0] x, y;
        bit                 typed;   // expected ray given in the row
        ray_result_t        ray;
    } point_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [crsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [crsp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [17:0] click_x = '0, click_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic in_view;
    logic signed [31:0] start_x, start_y, start_z, ray_length;
    logic signed [15:0] dir_x, dir_y, dir_z;

    // Predictor's copy of the camera registers
    logic        cam_persp;
    logic [62:0] cam_pos;
    logic [63:0] cam_quat;
    logic [63:0] cam_ortho;
    logic [31:0] cam_tan, cam_aspect;
    logic [30:0] cam_near, cam_far;

    ray_result_t pending_rays[$];
    int  mismatches = 0;
    int  rays_checked = 0;
    int  points_sent = 0;
    int  send_idle_pct = 0;
    int  take_stall_pct = 0;

    camera_ray_from_screen_point_unit dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic longint shr_round(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // v + 2*(w*(u x v) + u x (u x v)); q[0] is w
    function automatic void quat_rotate(input longint q[4], input longint v[3],
                                        output longint r[3]);
        longint uv[3], uuv[3];
        uv[0] = shr_round(q[2] * v[2] - q[3] * v[1], 14);
        uv[1] = shr_round(q[3] * v[0] - q[1] * v[2], 14);
        uv[2] = shr_round(q[1] * v[1] - q[2] * v[0], 14);
        uuv[0] = q[2] * uv[2] - q[3] * uv[1];
        uuv[1] = q[3] * uv[0] - q[1] * uv[2];
        uuv[2] = q[1] * uv[1] - q[2] * uv[0];
        for (int i = 0; i < 3; i++)
            r[i] = v[i] + shr_round(2 * (q[0] * uv[i] + uuv[i]), 14);
    endfunction

    function automatic ray_result_t predict_ray(logic signed [17:0] px,
                                                logic signed [17:0] py);
        ray_result_t o;
        longint x, y, dx, dy, q[4], pos[3], off[3], rot[3], dir[3], base[3], nv[3];
        longint unsigned at, n, m, c;
        o = '{default: '0};
        x = longint'(px);
        y = longint'(py);
        if (x < 0 || y < 0 || x > crsp_pkg::ONE_Q16 || y > crsp_pkg::ONE_Q16)
            return o;
        for (int i = 0; i < 4; i++)
            q[i] = longint'($signed(cam_quat[16*i +: 16]));
        for (int i = 0; i < 3; i++)
            pos[i] = longint'($signed(cam_pos[21*i +: 21])) * 64;
        dx = x - crsp_pkg::HALF_Q16;
        dy = crsp_pkg::HALF_Q16 - y;
        base = '{0, 0, -crsp_pkg::ONE_Q14};
        off[2] = -longint'({33'd0, cam_near});
        if (!cam_persp)
        begin
            off[0] = shr_round(longint'({32'd0, cam_ortho[31:0]}) * dx, 16);
            off[1] = shr_round(longint'({32'd0, cam_ortho[63:32]}) * dy, 16);
            quat_rotate(q, base, dir);
        end
        else
        begin
            at = ({32'd0, cam_aspect} * {32'd0, cam_tan} + crsp_pkg::HALF_Q16) >> 16;
            if (at > 64'hFFFF_FFFF)
                at = 64'hFFFF_FFFF;
            off[0] = shr_round(longint'(at) * dx, 16);
            off[1] = shr_round(longint'({32'd0, cam_tan}) * dy, 16);
            n = 0;
            for (int i = 0; i < 3; i++)
            begin
                m = off[i] < 0 ? -off[i] : off[i];
                n += m * m;
            end
            n = int_sqrt(n);
            if (n == 0)
                quat_rotate(q, base, dir);
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m = off[i] < 0 ? -off[i] : off[i];
                    c = (m * 2 * crsp_pkg::ONE_Q14 + n) / (2 * n);
                    nv[i] = off[i] < 0 ? -longint'(c) : longint'(c);
                end
                quat_rotate(q, nv, dir);
            end
        end
        quat_rotate(q, off, rot);
        o.in_view = 1'b1;
        o.start_x = 32'(sat(pos[0] + rot[0], -64'sd2147483648, 64'sd2147483647));
        o.start_y = 32'(sat(pos[1] + rot[1], -64'sd2147483648, 64'sd2147483647));
        o.start_z = 32'(sat(pos[2] + rot[2], -64'sd2147483648, 64'sd2147483647));
        o.dir_x = 16'(sat(dir[0], -crsp_pkg::ONE_Q14, crsp_pkg::ONE_Q14));
        o.dir_y = 16'(sat(dir[1], -crsp_pkg::ONE_Q14, crsp_pkg::ONE_Q14));
        o.dir_z = 16'(sat(dir[2], -crsp_pkg::ONE_Q14, crsp_pkg::ONE_Q14));
        o.ray_length = 32'(longint'({33'd0, cam_far}) - longint'({33'd0, cam_near}));
        return o;
    endfunction

    // ---------------- config ----------------
    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(crsp_pkg::cfg_reg_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            crsp_pkg::REG_MODE:     cam_persp  = value[0];
            crsp_pkg::REG_POSITION: cam_pos    = value[62:0];
            crsp_pkg::REG_ROTATION: cam_quat   = value;
            crsp_pkg::REG_ORTHO:    cam_ortho  = value;
            crsp_pkg::REG_TAN:      cam_tan    = value[31:0];
            crsp_pkg::REG_ASPECT:   cam_aspect = value[31:0];
            crsp_pkg::REG_NEAR:     cam_near   = value[30:0];
            crsp_pkg::REG_FAR:      cam_far    = value[30:0];
            default: ;
        endcase
    endtask

    task automatic load_camera(logic persp, logic [62:0] pos, logic [63:0] quat,
                               logic [63:0] ortho, logic [31:0] tanv,
                               logic [31:0] aspect, logic [30:0] nearv,
                               logic [30:0] farv);
        write_reg(crsp_pkg::REG_MODE, {63'd0, persp});
        write_reg(crsp_pkg::REG_POSITION, {1'b0, pos});
        write_reg(crsp_pkg::REG_ROTATION, quat);
        write_reg(crsp_pkg::REG_ORTHO, ortho);
        write_reg(crsp_pkg::REG_TAN, {32'd0, tanv});
        write_reg(crsp_pkg::REG_ASPECT, {32'd0, aspect});
        write_reg(crsp_pkg::REG_NEAR, {33'd0, nearv});
        write_reg(crsp_pkg::REG_FAR, {33'd0, farv});
        cfg_valid <= 1'b0;
    endtask

    // Pipeline has no items without results, so an empty queue means idle.
    task automatic drain;
        while (pending_rays.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ---------------- stimulus ----------------
    task automatic send_point(logic signed [17:0] px, logic signed [17:0] py,
                              bit typed, ray_result_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        click_x  <= px;
        click_y  <= py;
        do @(posedge clk); while (in_stall);
        pending_rays.push_back(typed ? want : predict_ray(px, py));
        points_sent++;
    endtask

    task automatic end_burst;
        in_valid <= 1'b0;
    endtask

    // Mostly on-screen points, with edges and off-screen noise mixed in
    function automatic logic signed [17:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 18'($urandom_range(crsp_pkg::ONE_Q16));
        else if (r < 80)
            return $urandom_range(1) ? 18'sd0 : 18'sd65536;
        else if (r < 85)
            return $urandom_range(1) ? 18'sd32768 : 18'sd65535;
        else
            return 18'($urandom);
    endfunction

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord(), 1'b0, '{default: '0});
        end_burst();
    endtask

    task automatic random_camera;
        logic [63:0] quat;
        logic [63:0] ortho;
        // unit-ish rotations usually, wild ones sometimes
        if ($urandom_range(3) == 0)
            quat = {$urandom, $urandom};
        else
            quat = {16'($urandom_range(crsp_pkg::ONE_Q14 * 2) - crsp_pkg::ONE_Q14),
                    16'($urandom_range(crsp_pkg::ONE_Q14 * 2) - crsp_pkg::ONE_Q14),
                    16'($urandom_range(crsp_pkg::ONE_Q14 * 2) - crsp_pkg::ONE_Q14),
                    16'($urandom_range(crsp_pkg::ONE_Q14 * 2) - crsp_pkg::ONE_Q14)};
        ortho = $urandom_range(1) ? {$urandom, $urandom}
                                  : {32'($urandom_range(32'h0010_0000)),
                                     32'($urandom_range(32'h0010_0000))};
        load_camera(1'($urandom_range(1)), 63'({$urandom, $urandom}), quat, ortho,
                    $urandom_range(1) ? $urandom : $urandom_range(32'h0003_0000),
                    $urandom_range(1) ? $urandom : $urandom_range(32'h0003_0000),
                    $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(32'h0010_0000)),
                    31'($urandom));
    endtask

    // Receiver: random stall per cycle
    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < take_stall_pct);
    end

    // Checker
    always @(posedge clk)
    begin
        ray_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rays.size() == 0)
            begin
                $error("ray with no point outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_rays.pop_front();
                rays_checked++;
                if (in_view !== want.in_view)
                begin
                    $error("in_view: expected %0d, got %0d", want.in_view, in_view);
                    mismatches++;
                end
                if (start_x !== want.start_x)
                begin
                    $error("start_x: expected %0d, got %0d", want.start_x, start_x);
                    mismatches++;
                end
                if (start_y !== want.start_y)
                begin
                    $error("start_y: expected %0d, got %0d", want.start_y, start_y);
                    mismatches++;
                end
                if (start_z !== want.start_z)
                begin
                    $error("start_z: expected %0d, got %0d", want.start_z, start_z);
                    mismatches++;
                end
                if (dir_x !== want.dir_x)
                begin
                    $error("dir_x: expected %0d, got %0d", want.dir_x, dir_x);
                    mismatches++;
                end
                if (dir_y !== want.dir_y)
                begin
                    $error("dir_y: expected %0d, got %0d", want.dir_y, dir_y);
                    mismatches++;
                end
                if (dir_z !== want.dir_z)
                begin
                    $error("dir_z: expected %0d, got %0d", want.dir_z, dir_z);
                    mismatches++;
                end
                if (ray_length !== want.ray_length)
                begin
                    $error("ray_length: expected %0d, got %0d",
                           want.ray_length, ray_length);
                    mismatches++;
                end
            end
        end
    end

    // Directed rows, run against the reset camera (perspective, origin,
    // identity rotation, tan 1, aspect 1, near 6554, far 100.0).
    // Off-screen rows have a fixed all-zero ray; the centre row looks
    // straight down -z, starting at -near.
    localparam ray_result_t OFF_RAY = '{default: '0};
    localparam ray_result_t CENTRE_RAY =
        '{1'b1, 32'sd0, 32'sd0, -32'sd6554, 16'sd0, 16'sd0, -16'sd16384,
          32'sd6547046};
    point_row_t directed_rows[] = '{
        '{18'sd32768,   18'sd32768,   1'b1, CENTRE_RAY},
        '{-18'sd1,      18'sd32768,   1'b1, OFF_RAY},
        '{18'sd32768,   -18'sd1,      1'b1, OFF_RAY},
        '{18'sd65537,   18'sd0,       1'b1, OFF_RAY},
        '{18'sd0,       18'sd65537,   1'b1, OFF_RAY},
        '{-18'sd131072, -18'sd131072, 1'b1, OFF_RAY},
        '{18'sd131071,  18'sd131071,  1'b1, OFF_RAY},
        '{-18'sd131072, 18'sd131071,  1'b1, OFF_RAY},
        '{18'sd0,       18'sd0,       1'b0, OFF_RAY},
        '{18'sd65536,   18'sd65536,   1'b0, OFF_RAY},
        '{18'sd0,       18'sd65536,   1'b0, OFF_RAY},
        '{18'sd65536,   18'sd0,       1'b0, OFF_RAY},
        '{18'sd1,       18'sd65535,   1'b0, OFF_RAY},
        '{18'sd43690,   18'sd21845,   1'b0, OFF_RAY}
    };

    initial
    begin
        cam_persp = 1'b1;   cam_pos = '0;       cam_quat = 64'd16384;
        cam_ortho = '0;     cam_tan = 32'd65536; cam_aspect = 32'd65536;
        cam_near = 31'd6554; cam_far = 31'd6553600;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_point(directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].typed, directed_rows[i].ray);
        end_burst();
        drain();

        // Special settings: near = 0 centre point (zero offset), orthographic,
        // an oversized quaternion, and all registers at their top values.
        load_camera(1'b1, '0, 64'd16384, '0, 32'd65536, 32'd65536, '0, '0);
        send_point(18'sd32768, 18'sd32768, 1'b0, OFF_RAY);
        send_point(18'sd0, 18'sd65536, 1'b0, OFF_RAY);
        end_burst();
        drain();
        load_camera(1'b0, 63'h0000_0400_0020_0400, 64'd16384,
                    {32'd131072, 32'd196608}, 32'd65536, 32'd65536, 31'd65536,
                    31'd655360);
        random_points(6);
        drain();
        load_camera(1'b1, '1, 64'h7FFF_8000_7FFF_8000, '1, '1, '1, '1, '1);
        random_points(6);
        drain();
        load_camera(1'b0, '1, '1, '1, '1, '1, '1, '0);
        random_points(6);
        drain();
        write_reg(crsp_pkg::REG_MODE, 64'd1);
        cfg_valid <= 1'b0;
        random_points(4);
        drain();

        // Random phases: idle patterns, then fresh cameras each block
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct  = (ph == 0) ? 28 : (ph == 1) ? 56 : 0;
            take_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 28 : 0;
            for (int b = 0; b < 6; b++)
            begin
                random_camera();
                random_points(95);
                drain();
            end
        end

        take_stall_pct = 0;
        repeat (LATENCY + 10) @(posedge clk);
        if (pending_rays.size() != 0)
        begin
            $error("%0d rays never arrived", pending_rays.size());
            mismatches++;
        end
        $display("Sent %0d screen points over many camera settings, checked %0d rays.",
                 points_sent, rays_checked);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
